// ===== design/sliding_dft_update_assert.svh =====
// assertion macros for the sliding dft update block
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef SLIDING_DFT_UPDATE_ASSERT_SVH
`define SLIDING_DFT_UPDATE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SDFT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sliding dft check failed");

// next-cycle implication, checked outside reset
`define SDFT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sliding dft check failed");

`endif

// ===== design/sdft_pkg.sv =====
// shared types and constants of the sliding dft update block
// no dependencies
`default_nettype none

package sdft_pkg;

  localparam int unsigned SampleW    = 16;
  localparam int unsigned BinW       = 40;
  localparam int unsigned BinIdxW    = 6;
  localparam int unsigned CoefW      = 18;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned MacLatency = 3;
  localparam logic [63:0] PiHalfQ30  = 64'd1686629713;

  typedef enum logic {
    StIdle,
    StRun
  } sdft_state_e;

  // travels with each bin through the multiply-add stages
  typedef struct packed {
    logic                valid;
    logic [BinIdxW-1:0]  index;
    logic                last;
  } sdft_tag_t;

endpackage

`default_nettype wire

// ===== design/sdft_sample_if.sv =====
// valid/ready channel that carries one input sample
// depends on sdft_pkg
`default_nettype none

interface sdft_sample_if;
  import sdft_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== design/sdft_bin_if.sv =====
// valid/ready channel that carries one updated bin
// depends on sdft_pkg
`default_nettype none

interface sdft_bin_if;
  import sdft_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [BinIdxW-1:0]      bin_index;
  logic signed [BinW-1:0]  bin_real;
  logic signed [BinW-1:0]  bin_imag;
  logic                    last;

  modport source (output valid, output bin_index, output bin_real, output bin_imag,
                  output last, input ready);
  modport sink   (input valid, input bin_index, input bin_real, input bin_imag,
                  input last, output ready);
endinterface

`default_nettype wire

// ===== design/sliding_dft_update.sv =====
// sliding dft update: a sliding discrete Fourier transform over the last BINS
// samples. Each sample transfer replaces the oldest sample in the window;
// delta = new - oldest, and every bin k becomes bin(k) * exp(+j*2*pi*k/BINS)
// + delta, rounded to 16 fraction bits and saturated to 40 bits. All BINS
// updated bins are then sent in index order, the final one flagged by last.
// The bins live in a circular chain of cells that rotates once per sample
// through one shared three-stage complex multiply-add unit, so a new sample
// transfers only after the previous rotation is over: the sample transfers
// in the idle state, then BINS+3 steps walk every bin through the unit and
// the updated bins come out one per cycle while the output is not stalled.
// A stalled bin output freezes the chain and the unit. Samples and bins
// clear at reset. Depends on sdft_pkg,
// sdft_sample_if, sdft_bin_if, sdft_cell, sdft_mac and
// sliding_dft_update_assert.svh.
`default_nettype none
`include "sliding_dft_update_assert.svh"

module sliding_dft_update #(
  parameter int unsigned BINS        = 32,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sdft_sample_if.sink smp_i,
  sdft_bin_if.source  bin_o
);
  import sdft_pkg::*;

  localparam int unsigned StepW   = $clog2(BINS + MacLatency);
  localparam int unsigned RomIdxW = $clog2(BINS);
  localparam int unsigned DeltaW  = SAMPLE_BITS + 1 + FracBits;
  localparam logic [StepW-1:0] StepLast    = StepW'(BINS + MacLatency - 1);
  localparam logic [StepW-1:0] StepBins    = StepW'(BINS);
  localparam logic [StepW-1:0] StepBinLast = StepW'(BINS - 1);

  // truncating division of a taylor term by its order
  function automatic logic [63:0] div_order(input logic [63:0] v, input int unsigned n);
    case (n)
      2:       return v / 64'd2;
      3:       return v / 64'd3;
      4:       return v / 64'd4;
      5:       return v / 64'd5;
      6:       return v / 64'd6;
      7:       return v / 64'd7;
      8:       return v / 64'd8;
      9:       return v / 64'd9;
      10:      return v / 64'd10;
      11:      return v / 64'd11;
      12:      return v / 64'd12;
      13:      return v / 64'd13;
      14:      return v / 64'd14;
      15:      return v / 64'd15;
      16:      return v / 64'd16;
      17:      return v / 64'd17;
      18:      return v / 64'd18;
      19:      return v / 64'd19;
      20:      return v / 64'd20;
      default: return v;
    endcase
  endfunction

  // twiddle k as {re, im} in q1.16: first-quadrant angle by taylor series in q30,
  // rounded to q16, then turned by whole quarter turns
  function automatic logic [2*CoefW-1:0] coef_entry(input int unsigned k);
    int unsigned quad;
    int unsigned rem;
    logic [63:0] x;
    logic [63:0] term;
    longint      c;
    longint      s;
    longint      cq;
    longint      sq;
    longint      wr;
    longint      wi;
    quad = (4 * k) / BINS;
    rem  = (4 * k) % BINS;
    x    = (PiHalfQ30 * 64'(rem)) / 64'(BINS);
    term = 64'd1 << 30;
    c    = 0;
    s    = 0;
    for (int unsigned n = 0; n <= 20; n++) begin
      if (n > 0) begin
        term = div_order((term * x) >> 30, n);
      end
      case (n & 3)
        0:       c = c + longint'(term);
        1:       s = s + longint'(term);
        2:       c = c - longint'(term);
        default: s = s - longint'(term);
      endcase
    end
    if (c < 0) begin
      c = 0;
    end
    if (s < 0) begin
      s = 0;
    end
    cq = (c + 8192) >>> 14;
    sq = (s + 8192) >>> 14;
    case (quad & 3)
      0: begin
        wr = cq;
        wi = sq;
      end
      1: begin
        wr = -sq;
        wi = cq;
      end
      2: begin
        wr = -cq;
        wi = -sq;
      end
      default: begin
        wr = sq;
        wi = -cq;
      end
    endcase
    return {CoefW'(wr), CoefW'(wi)};
  endfunction

  // control
  sdft_state_e              state_q, state_d;
  logic [StepW-1:0]         step_q, step_d;
  logic                     accept;
  logic                     advance;
  logic                     shift;
  logic                     issue;

  // sample window and delta
  logic [SAMPLE_BITS+SampleW-1:0] raw_ext;
  logic signed [SAMPLE_BITS-1:0]  new_smp;
  logic signed [SAMPLE_BITS-1:0]  old_smp;
  logic signed [SAMPLE_BITS:0]    diff;
  logic signed [DeltaW-1:0]       delta_d, delta_q;
  logic [SAMPLE_BITS-1:0]         smp_chain [BINS];

  // bin chain, twiddle table and the multiply-add unit
  logic [2*BinW-1:0]        bin_chain [BINS];
  logic [2*CoefW-1:0]       rom_tab [BINS];
  logic [RomIdxW-1:0]       rom_idx;
  logic [2*CoefW-1:0]       coef;
  sdft_tag_t                tag_in;
  sdft_tag_t                tag_out;
  logic signed [BinW-1:0]   re_out;
  logic signed [BinW-1:0]   im_out;

  // the multiply-add output register doubles as the bin output register,
  // so everything moves whenever it is empty or being taken
  assign advance = !tag_out.valid || bin_o.ready;
  assign accept  = smp_i.valid && smp_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // next state: one rotation of BINS + pipeline depth steps per sample
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StRun;
          step_d  = '0;
        end
      end
      StRun: begin
        if (advance) begin
          if (step_q == StepLast) begin
            state_d = StIdle;
            step_d  = '0;
          end else begin
            step_d = step_q + StepW'(1);
          end
        end
      end
      default: begin
        state_d = StIdle;
        step_d  = '0;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    smp_i.ready = 1'b0;
    shift       = 1'b0;
    issue       = 1'b0;
    case (state_q)
      StIdle: begin
        smp_i.ready = 1'b1;
      end
      StRun: begin
        shift = advance;
        issue = step_q < StepBins;
      end
      default: begin
        smp_i.ready = 1'b0;
      end
    endcase
  end

  // sample bits above SAMPLE_BITS are dropped, narrower ones zero-fill
  always_comb begin
    raw_ext = {SAMPLE_BITS'(0), smp_i.sample};
    new_smp = raw_ext[SAMPLE_BITS-1:0];
    old_smp = smp_chain[0];
    diff    = {new_smp[SAMPLE_BITS-1], new_smp} - {old_smp[SAMPLE_BITS-1], old_smp};
    delta_d = {diff, FracBits'(0)};
  end

  // delta holds for the whole rotation
  always_ff @(posedge clk_i) begin
    if (accept) begin
      delta_q <= delta_d;
    end
  end

  // window as a delay line: cell 0 holds the oldest sample
  for (genvar i = 0; i < BINS; i++) begin : g_smp
    if (i == BINS - 1) begin : g_tail
      sdft_cell #(.Width(SAMPLE_BITS)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (accept),
        .d_i    (new_smp),
        .q_o    (smp_chain[i])
      );
    end else begin : g_body
      sdft_cell #(.Width(SAMPLE_BITS)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (accept),
        .d_i    (smp_chain[i+1]),
        .q_o    (smp_chain[i])
      );
    end
  end

  // bin ring: head feeds the unit, the unit's result refills the tail;
  // after BINS + 3 shifts the updated bins sit back in index order
  for (genvar i = 0; i < BINS; i++) begin : g_bin
    if (i == BINS - 1) begin : g_tail
      sdft_cell #(.Width(2 * BinW)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (shift),
        .d_i    ({re_out, im_out}),
        .q_o    (bin_chain[i])
      );
    end else begin : g_body
      sdft_cell #(.Width(2 * BinW)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (shift),
        .d_i    (bin_chain[i+1]),
        .q_o    (bin_chain[i])
      );
    end
  end

  // twiddle table, built at elaboration
  for (genvar k = 0; k < BINS; k++) begin : g_rom
    localparam logic [2*CoefW-1:0] Entry = coef_entry(k);
    assign rom_tab[k] = Entry;
  end

  always_comb begin
    rom_idx      = issue ? RomIdxW'(step_q) : '0;
    coef         = rom_tab[rom_idx];
    tag_in.valid = issue;
    tag_in.index = BinIdxW'(step_q);
    tag_in.last  = issue && (step_q == StepBinLast);
  end

  sdft_mac #(.DeltaW(DeltaW)) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .re_i    (bin_chain[0][2*BinW-1:BinW]),
    .im_i    (bin_chain[0][BinW-1:0]),
    .wr_i    (coef[2*CoefW-1:CoefW]),
    .wi_i    (coef[CoefW-1:0]),
    .delta_i (delta_q),
    .tag_i   (tag_in),
    .re_o    (re_out),
    .im_o    (im_out),
    .tag_o   (tag_out)
  );

  assign bin_o.valid     = tag_out.valid;
  assign bin_o.bin_index = tag_out.index;
  assign bin_o.bin_real  = re_out;
  assign bin_o.bin_imag  = im_out;
  assign bin_o.last      = tag_out.last;

  // no bin is pending once the rotation is over
  `SDFT_ASSERT_NOW(a_idle_no_bin, state_q == StIdle, !bin_o.valid)
  // the transfer of the final bin closes the rotation
  `SDFT_ASSERT_NEXT(a_last_ends_run, bin_o.valid && bin_o.ready && bin_o.last, state_q == StIdle)
  // last marks exactly the top bin
  `SDFT_ASSERT_NOW(a_last_is_top, bin_o.valid, bin_o.last == (bin_o.bin_index == BinIdxW'(BINS - 1)))
  // a sample transfer starts a fresh rotation
  `SDFT_ASSERT_NEXT(a_accept_starts, accept, (state_q == StRun) && (step_q == '0))

endmodule

`default_nettype wire

// ===== design/sdft_cell.sv =====
// one cell of a shift chain: a register that takes its neighbor's value when enabled
// no dependencies
`default_nettype none

module sdft_cell #(
  parameter int unsigned Width = 40
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [Width-1:0] d_i,
  output logic [Width-1:0] q_o
);

  logic [Width-1:0] data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (en_i) begin
      data_q <= d_i;
    end
  end

  assign q_o = data_q;

endmodule

`default_nettype wire

// ===== design/sdft_mac.sv =====
// three-stage complex multiply, round, add delta and saturate, one bin per cycle while en_i is high
// depends on sdft_pkg
`default_nettype none

module sdft_mac #(
  parameter int unsigned DeltaW = 33
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic signed [sdft_pkg::BinW-1:0]  re_i,
  input  logic signed [sdft_pkg::BinW-1:0]  im_i,
  input  logic signed [sdft_pkg::CoefW-1:0] wr_i,
  input  logic signed [sdft_pkg::CoefW-1:0] wi_i,
  input  logic signed [DeltaW-1:0]          delta_i,
  input  sdft_pkg::sdft_tag_t               tag_i,
  output logic signed [sdft_pkg::BinW-1:0]  re_o,
  output logic signed [sdft_pkg::BinW-1:0]  im_o,
  output sdft_pkg::sdft_tag_t               tag_o
);
  import sdft_pkg::*;

  localparam int unsigned ProdW = BinW + CoefW;
  localparam int unsigned RndW  = ProdW + 1;
  localparam int unsigned TrW   = RndW - FracBits;
  localparam int unsigned SumW  = ((TrW > DeltaW) ? TrW : DeltaW) + 1;
  localparam logic signed [RndW-1:0] RoundHalf = RndW'(2 ** (FracBits - 1));
  localparam logic signed [BinW-1:0] BinMax    = {1'b0, {(BinW - 1){1'b1}}};
  localparam logic signed [BinW-1:0] BinMin    = {1'b1, {(BinW - 1){1'b0}}};

  function automatic logic signed [BinW-1:0] sat_bin(input logic signed [SumW-1:0] v);
    logic [SumW-BinW:0] top;
    top = v[SumW-1:BinW-1];
    if ((&top) || !(|top)) begin
      return BinW'(v);
    end else if (v[SumW-1]) begin
      return BinMin;
    end
    return BinMax;
  endfunction

  // stage 1: four products
  logic signed [ProdW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  sdft_tag_t               tag1_q;
  // stage 2: combined and rounded
  logic signed [RndW-1:0]  sr_d, si_d, sr_q, si_q;
  sdft_tag_t               tag2_q;
  // stage 3: shifted, delta added, saturated
  logic signed [TrW-1:0]   tr_r, tr_i;
  logic signed [SumW-1:0]  sum_r, sum_i;
  logic signed [BinW-1:0]  re_d, im_d, re_q, im_q;
  sdft_tag_t               tag3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else if (en_i) begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_rr_q <= re_i * wr_i;
      p_ii_q <= im_i * wi_i;
      p_ri_q <= re_i * wi_i;
      p_ir_q <= im_i * wr_i;
      sr_q   <= sr_d;
      si_q   <= si_d;
      re_q   <= re_d;
      im_q   <= im_d;
    end
  end

  always_comb begin
    sr_d = RndW'(p_rr_q) - RndW'(p_ii_q) + RoundHalf;
    si_d = RndW'(p_ri_q) + RndW'(p_ir_q) + RoundHalf;
  end

  always_comb begin
    tr_r  = TrW'(sr_q >>> FracBits);
    tr_i  = TrW'(si_q >>> FracBits);
    sum_r = SumW'(tr_r) + SumW'(delta_i);
    sum_i = SumW'(tr_i);
    re_d  = sat_bin(sum_r);
    im_d  = sat_bin(sum_i);
  end

  assign re_o  = re_q;
  assign im_o  = im_q;
  assign tag_o = tag3_q;

endmodule

`default_nettype wire

// ===== test/tb_sliding_dft_update.sv =====
// self-checking testbench for the sliding dft update block: drives sample transfers,
// predicts every updated bin in fixed point and checks each bin transfer in order
// depends on sdft_pkg, sdft_sample_if, sdft_bin_if and sliding_dft_update
`default_nettype none

module tb_sliding_dft_update;
  timeunit 1ns;
  timeprecision 1ps;

  import sdft_pkg::*;

  localparam int unsigned BINS          = 32;
  localparam int unsigned SAMPLE_BITS   = 16;
  localparam int          WatchdogLimit = 4000;
  localparam int          TailCycles    = BINS + 12;
  localparam longint      BinMax        = 64'sd549755813887;
  localparam longint      BinMin        = -BinMax - 1;

  // one expected bin transfer
  typedef struct {
    logic [BinIdxW-1:0] index;
    logic [BinW-1:0]    re;
    logic [BinW-1:0]    im;
    logic               last;
  } bin_result_t;

  logic clk_i;
  logic rst_ni;

  sdft_sample_if smp_ch ();
  sdft_bin_if    bin_ch ();

  sliding_dft_update #(
    .BINS        (BINS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .smp_i  (smp_ch),
    .bin_o  (bin_ch)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor state: sample window, write position, bin accumulators and the
  // rotation factors exp(+j*2*pi*k/BINS) in Q1.16
  // ---------------------------------------------------------------------------
  logic signed [SampleW-1:0] window_ring [BINS];
  int unsigned               window_pos;
  longint                    bin_re_acc  [BINS];
  longint                    bin_im_acc  [BINS];
  longint                    twiddle_re  [BINS];
  longint                    twiddle_im  [BINS];

  bin_result_t pending_bins [$];

  int snd_idle_pct;
  int rcv_idle_pct;
  int err_cnt;
  int samples_sent;
  int bins_checked;
  int quiet_cycles;

  // first-quadrant angle by Taylor series in Q30, rounded to Q16 and then
  // rotated into the right quadrant
  function automatic void build_twiddles();
    longint unsigned x;
    longint unsigned term;
    int unsigned     quad;
    int unsigned     rem;
    longint          c;
    longint          s;
    longint          cq;
    longint          sq;
    for (int k = 0; k < BINS; k++) begin
      quad = (4 * k) / BINS;
      rem  = (4 * k) % BINS;
      x    = (64'(PiHalfQ30) * rem) / BINS;
      term = 64'd1 << 30;
      c    = 0;
      s    = 0;
      for (int n = 0; n <= 20; n++) begin
        if (n > 0) begin
          term = ((term * x) >> 30) / longint'(n);
        end
        case (n % 4)
          0: c += longint'(term);
          1: s += longint'(term);
          2: c -= longint'(term);
          default: s -= longint'(term);
        endcase
      end
      if (c < 0) c = 0;
      if (s < 0) s = 0;
      // Q30 to Q16, half away from zero (both are non-negative here)
      cq = (c + 8192) >>> 14;
      sq = (s + 8192) >>> 14;
      case (quad % 4)
        0: begin
          twiddle_re[k] = cq;  twiddle_im[k] = sq;
        end
        1: begin
          twiddle_re[k] = -sq; twiddle_im[k] = cq;
        end
        2: begin
          twiddle_re[k] = -cq; twiddle_im[k] = -sq;
        end
        default: begin
          twiddle_re[k] = sq;  twiddle_im[k] = -cq;
        end
      endcase
    end
  endfunction

  function automatic longint clip40(input longint v);
    if (v > BinMax) return BinMax;
    if (v < BinMin) return BinMin;
    return v;
  endfunction

  // slide the window by one sample and queue the BINS updated bins it produces
  function automatic void slide_window(input logic signed [SampleW-1:0] s);
    longint      delta;
    longint      prod_re;
    longint      prod_im;
    bin_result_t r;
    delta = (longint'(s) - longint'(window_ring[window_pos])) * 65536;
    window_ring[window_pos] = s;
    for (int k = 0; k < BINS; k++) begin
      prod_re = bin_re_acc[k] * twiddle_re[k] - bin_im_acc[k] * twiddle_im[k];
      prod_im = bin_re_acc[k] * twiddle_im[k] + bin_im_acc[k] * twiddle_re[k];
      // round half up to Q16 (floor after adding one half), then add delta
      bin_re_acc[k] = clip40(((prod_re + 32768) >>> 16) + delta);
      bin_im_acc[k] = clip40((prod_im + 32768) >>> 16);
      r.index = BinIdxW'(k);
      r.re    = bin_re_acc[k][BinW-1:0];
      r.im    = bin_im_acc[k][BinW-1:0];
      r.last  = (k == BINS - 1);
      pending_bins.push_back(r);
    end
    window_pos = (window_pos + 1) % BINS;
  endfunction

  // ---------------------------------------------------------------------------
  // sample sender: returns in the time step of the accepting edge and leaves
  // valid high, so back-to-back samples never toggle valid within one step
  // ---------------------------------------------------------------------------
  task automatic send_sample(input logic signed [SampleW-1:0] s);
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      smp_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < snd_idle_pct);
    end
    smp_ch.valid  <= 1'b1;
    smp_ch.sample <= s;
    do @(posedge clk_i); while (!smp_ch.ready);
    slide_window(s);
    samples_sent++;
  endtask

  // drop valid and hold off until every queued bin has come out
  task automatic hold_until_drained();
    smp_ch.valid <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // bin receiver: random back-pressure, one nonblocking update per edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    bin_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // bin checker: every bin transfer against the oldest expectation
  always @(posedge clk_i) begin
    bin_result_t exp_bin;
    if (rst_ni && bin_ch.valid && bin_ch.ready) begin
      if (pending_bins.size() == 0) begin
        $display("%0t: unexpected bin transfer, expected none, actual index %0d re %h im %h",
                 $realtime, bin_ch.bin_index, bin_ch.bin_real, bin_ch.bin_imag);
        err_cnt++;
      end else begin
        exp_bin = pending_bins.pop_front();
        bins_checked++;
        if (bin_ch.bin_index !== exp_bin.index) begin
          $display("%0t: bin_index mismatch, expected %0d actual %0d",
                   $realtime, exp_bin.index, bin_ch.bin_index);
          err_cnt++;
        end
        if (bin_ch.bin_real !== exp_bin.re) begin
          $display("%0t: bin_real mismatch at bin %0d, expected %h actual %h",
                   $realtime, exp_bin.index, exp_bin.re, bin_ch.bin_real);
          err_cnt++;
        end
        if (bin_ch.bin_imag !== exp_bin.im) begin
          $display("%0t: bin_imag mismatch at bin %0d, expected %h actual %h",
                   $realtime, exp_bin.index, exp_bin.im, bin_ch.bin_imag);
          err_cnt++;
        end
        if (bin_ch.last !== exp_bin.last) begin
          $display("%0t: last mismatch at bin %0d, expected %b actual %b",
                   $realtime, exp_bin.index, exp_bin.last, bin_ch.last);
          err_cnt++;
        end
      end
    end
  end

  // watchdog: too many cycles in a row without any transfer ends the run
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles = 0;
    end else if ((smp_ch.valid && smp_ch.ready) || (bin_ch.valid && bin_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no transfer for %0d cycles, %0d bins outstanding",
                 $realtime, WatchdogLimit, pending_bins.size());
        $display("FAIL sliding_dft_update");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // full-scale steps in both directions: largest positive and negative delta,
  // the first sample after reset and alternating bit patterns
  task automatic test_extremes();
    send_sample(16'sd0);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
  endtask

  // a single one walking across the magnitude bits
  task automatic test_bit_walk();
    for (int b = 0; b < SampleW - 1; b++) begin
      send_sample(SampleW'(1) << b);
    end
  endtask

  // the sender waits for the pipeline to empty between short bursts
  task automatic test_drain_pause();
    for (int burst = 0; burst < 3; burst++) begin
      hold_until_drained();
      repeat ($urandom_range(1, 4)) send_sample(SampleW'($urandom()));
    end
  endtask

  // random samples: mostly full range, some small, some at the rails, and a
  // rare full drain so the window wraps with gaps in every phase
  task automatic test_random(input int count);
    logic signed [SampleW-1:0] s;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1:    s = SampleW'($urandom_range(0, 15)) - SampleW'(8);
        2:       s = ($urandom_range(0, 1) != 0) ? 16'sd32767 : -16'sd32768;
        default: s = SampleW'($urandom());
      endcase
      if ($urandom_range(0, 39) == 0) hold_until_drained();
      send_sample(s);
    end
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    smp_ch.valid  = 1'b0;
    smp_ch.sample = '0;
    bin_ch.ready  = 1'b0;
    err_cnt       = 0;
    samples_sent  = 0;
    bins_checked  = 0;
    quiet_cycles  = 0;
    snd_idle_pct  = 16;
    rcv_idle_pct  = 81;
    window_pos    = 0;
    for (int k = 0; k < BINS; k++) begin
      window_ring[k] = '0;
      bin_re_acc[k]  = 0;
      bin_im_acc[k]  = 0;
    end
    build_twiddles();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender lightly idle, receiver heavily stalled
    test_extremes();
    test_bit_walk();
    test_drain_pause();
    test_random(105);

    // roles swapped
    snd_idle_pct = 81;
    rcv_idle_pct = 16;
    test_random(105);

    // full rate on both sides
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random(100);

    hold_until_drained();
    repeat (TailCycles) @(posedge clk_i);

    $display("covered %0d samples and %0d checked bins over three idle/stall mixes,",
             samples_sent, bins_checked);
    $display("with rail-to-rail steps, walking bits, drained pauses and window wrap");
    if (err_cnt == 0 && pending_bins.size() == 0) begin
      $display("PASS sliding_dft_update");
    end else begin
      $display("FAIL sliding_dft_update");
    end
    $finish;
  end

endmodule

`default_nettype wire
